[hdl/sks_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sks_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_FIND   = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // request broadcast to every cell of the chain
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [KEY_W-1:0] key;
    } sks_cmd_t;

endpackage

`default_nettype wire

[hdl/sorted_key_set_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// sorted key set: holds up to CAPACITY distinct signed 32-bit keys in
// ascending order inside a row of cells, one key per cell
// input channel (s_*): one request per handshake; s_tuser carries the
// action (insert, find, delete), s_tdata the key
// output channel (m_*): exactly one result per request, in request order;
// m_tdata carries the status and the number of keys held afterwards
// timing: a request is taken in the idle state and executed in the exec state,
// where every cell compares its key with the request key at once and the whole
// row shifts by one place towards or away from the insertion/removal point
// a new request is not accepted until the last one has executed in the
// compare-and-shift step of the cell row
// the result sits in an output register; a new request is accepted while
// it waits, but execution holds until the receiver has taken the old one
// reset empties the set: all cell valid flags and the count clear at once
module sorted_key_set_unit
    import sks_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] key
    input  wire logic [1:0]  s_tuser,   // [1:0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata    // [1:0] status, [6:2] entry_count, [7] zero
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t             state_reg;
    logic [ACT_W-1:0]   act_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               m_tvalid_reg;
    logic [7:0]         m_tdata_reg;

    // per-cell taps of the chain
    logic [KEY_W-1:0]   cell_key   [CAPACITY];
    logic               cell_valid [CAPACITY];
    logic               cell_less  [CAPACITY];
    logic [CAPACITY-1:0] cell_equal;

    sks_cmd_t           cmd;
    logic               exec_go;
    logic               present;
    logic               full;
    status_t            status;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // execute once the output register is free or being emptied
    assign exec_go = (state_reg == S_EXEC) && (!m_tvalid_reg || m_tready);
    assign present = |cell_equal;
    assign full    = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        cmd.key    = key_reg;
        cmd.ins    = 1'b0;
        cmd.del    = 1'b0;
        status     = ST_MISS;
        count_next = count_reg;
        unique case (act_reg)
            ACT_INSERT:
            begin
                if (present)
                begin
                    status = ST_MISS;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    status     = ST_OK;
                    cmd.ins    = exec_go;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_FIND:
            begin
                status = present ? ST_OK : ST_MISS;
            end
            ACT_DELETE:
            begin
                if (present)
                begin
                    status     = ST_OK;
                    cmd.del    = exec_go;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status = ST_MISS;
            end
        endcase
    end

    // count reported modulo 32
    assign count_ext = {{COUNT_W{1'b0}}, count_next};

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [KEY_W-1:0] lk;
            logic             lv;
            logic             ll;
            logic [KEY_W-1:0] rk;
            logic             rv;

            if (gi == 0)
            begin : g_first
                // nothing sorts below the head of the row
                assign lk = '0;
                assign lv = 1'b1;
                assign ll = 1'b1;
            end
            else
            begin : g_mid
                assign lk = cell_key[gi-1];
                assign lv = cell_valid[gi-1];
                assign ll = cell_less[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign rk = '0;
                assign rv = 1'b0;
            end
            else
            begin : g_body
                assign rk = cell_key[gi+1];
                assign rv = cell_valid[gi+1];
            end

            sks_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .left_key    (lk),
                .left_valid  (lv),
                .left_less   (ll),
                .right_key   (rk),
                .right_valid (rv),
                .key         (cell_key[gi]),
                .valid       (cell_valid[gi]),
                .less        (cell_less[gi]),
                .equal       (cell_equal[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (m_tvalid_reg && m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                    end
                    if (s_tvalid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (exec_go)
                    begin
                        count_reg    <= count_next;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            act_reg <= s_tuser;
            key_reg <= s_tdata;
        end
        if (exec_go)
        begin
            m_tdata_reg <= {1'b0, count_ext[COUNT_W-1:0], status};
        end
    end

endmodule

`default_nettype wire

[hdl/sks_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module sks_cell
    import sks_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sks_cmd_t         cmd,
    input  wire logic [KEY_W-1:0] left_key,
    input  wire logic             left_valid,
    input  wire logic             left_less,
    input  wire logic [KEY_W-1:0] right_key,
    input  wire logic             right_valid,
    output logic      [KEY_W-1:0] key,
    output logic                  valid,
    output logic                  less,
    output logic                  equal
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             valid_reg;
    logic             valid_next;

    assign key   = key_reg;
    assign valid = valid_reg;
    // held key sorts below the request key (signed order)
    assign less  = valid_reg && ($signed(key_reg) < $signed(cmd.key));
    assign equal = valid_reg && (key_reg == cmd.key);

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (cmd.ins && !less)
        begin
            if (left_less)
            begin
                // insertion point
                key_next   = cmd.key;
                valid_next = 1'b1;
            end
            else
            begin
                key_next   = left_key;
                valid_next = left_valid;
            end
        end
        else if (cmd.del && !less)
        begin
            key_next   = right_key;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

[hdl/sks_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module sks_checker
    import sks_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [31:0] s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a request is not taken while the previous one is executing
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken on consecutive cycles");

    // no status code beyond store full
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("undefined status code");

    // store full only reported with a full count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == ST_FULL) |->
            (m_tdata[6:2] == COUNT_W'(CAPACITY)))
        else $error("store full with spare room");

    // count never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (CAPACITY > 31) || (m_tdata[6:2] <= COUNT_W'(CAPACITY)))
        else $error("count beyond capacity");

endmodule

bind sorted_key_set_unit sks_checker u_sks_checker (.*);

`default_nettype wire
